### src/dc_blocked_mixer_ring_top_defines.svh
// Assertion helpers for the mixer ring.
`ifndef DC_BLOCKED_MIXER_RING_TOP_DEFINES_SVH
`define DC_BLOCKED_MIXER_RING_TOP_DEFINES_SVH

// Clocked property, quiet while reset is applied.
`define DBM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the following clock.
`define DBM_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### src/dbm_pkg.sv
package dbm_pkg;

	localparam int RING_FRAMES = 4096;
	localparam int RING_AW     = $clog2(RING_FRAMES);

	localparam int SAMPLE_W = 16;
	localparam int WAVE_W   = 8;
	localparam int SUM_W    = 11;   // five 8-bit channels, max 1275
	localparam int AC_W     = 12;   // sum - estimate, -1275..1275
	localparam int GAIN_W   = 10;
	localparam int SHIFT_W  = 4;
	localparam int PROD_W   = AC_W + GAIN_W;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(40);
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(8);

	localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32767);
	localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(32768);

	localparam logic [SUM_W-1:0] DC_MAX = SUM_W'(1275);

	typedef enum logic [0:0] {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_GAIN     = 1'b0,
		REG_DC_SHIFT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cmd_t              command;
		logic [WAVE_W-1:0] wave_pulse_one;
		logic [WAVE_W-1:0] wave_pulse_two;
		logic [WAVE_W-1:0] wave_triangle;
		logic [WAVE_W-1:0] wave_noise;
		logic [WAVE_W-1:0] wave_dpcm;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic                       frame_valid;
	} out_word_t;

endpackage

### src/dbm_ram.sv
module dbm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/dbm_mix.sv
module dbm_mix
	import dbm_pkg::*;
(
	input  in_word_t                   word,
	input  logic [SUM_W-1:0]           dc_est,
	input  logic [GAIN_W-1:0]          gain,
	input  logic [SHIFT_W-1:0]         dc_shift,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic [SUM_W-1:0]           dc_next
);

	logic [SUM_W-1:0]         sum;
	logic signed [AC_W-1:0]   ac;
	logic signed [AC_W-1:0]   step;
	logic signed [AC_W-1:0]   dc_wide;
	logic signed [PROD_W-1:0] prod;

	always_comb begin
		sum = SUM_W'(word.wave_pulse_one) + SUM_W'(word.wave_pulse_two)
		    + SUM_W'(word.wave_triangle) + SUM_W'(word.wave_noise)
		    + SUM_W'(word.wave_dpcm);
		ac = $signed(AC_W'(sum)) - $signed(AC_W'(dc_est));
		// >>> on signed floors, matching the tracker's rounding
		step    = ac >>> dc_shift;
		dc_wide = $signed(AC_W'(dc_est)) + step;
		dc_next = dc_wide[SUM_W-1:0];
		prod = PROD_W'(ac) * $signed({1'b0, gain});
		if (prod > SAT_MAX) begin
			sample = SAMPLE_W'(SAT_MAX);
		end else if (prod < SAT_MIN) begin
			sample = SAMPLE_W'(SAT_MIN);
		end else begin
			sample = prod[SAMPLE_W-1:0];
		end
	end

endmodule

### src/dc_blocked_mixer_ring_top.sv
// Five-channel mono mixer with a one-pole DC blocker feeding a sample ring.
// A push word mixes its five channel samples, removes the tracked DC level,
// scales by gain, clamps to 16 bits and stores the result in a 4096-entry
// ring; it produces no output word. A pop word returns the oldest stored
// sample on both left and right with frame_valid set, or zeros with
// frame_valid clear when the ring is empty. Pushes never check for a full
// ring: the 4096th unread push wraps onto the read pointer and the ring reads
// empty. One word is taken per cycle while no pop waits on a stalled result.
// A word sits in the input register, where the mix, the DC update and the
// ring access happen; a pop result appears in the next cycle from the ring's
// registered read port, held until taken. No clearing pass after reset.
module dc_blocked_mixer_ring_top
	import dbm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  in_word_t     in_word,
	output logic         out_valid,
	input  logic         out_stall,
	output out_word_t    out_word,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  cfg_reg_t     cfg_index,
	input  logic [GAIN_W-1:0] cfg_data
);

`include "dc_blocked_mixer_ring_top_defines.svh"

	logic [GAIN_W-1:0]  gain_q;
	logic [SHIFT_W-1:0] dc_shift_q;
	logic [SUM_W-1:0]   dc_q;
	logic [RING_AW-1:0] wr_q;
	logic [RING_AW-1:0] rd_q;

	logic     v_s1;
	in_word_t item_s1;
	logic     v_s2;
	logic     fv_s2;

	logic s2_open, fire_s1, push_fire, pop_fire, ring_empty, accept, rd_en;
	logic signed [SAMPLE_W-1:0] mix_sample;
	logic [SUM_W-1:0]           dc_next;
	logic [SAMPLE_W-1:0]        ring_rdata;
	logic [RING_AW-1:0]         wr_next, rd_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= GAIN_RESET;
			dc_shift_q <= SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN:     gain_q <= cfg_data;
				REG_DC_SHIFT: dc_shift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// a pop needs the result stage free; a push only touches local state
	assign s2_open    = !v_s2 || !out_stall;
	assign fire_s1    = v_s1 && (item_s1.command == CMD_PUSH || s2_open);
	assign push_fire  = fire_s1 && item_s1.command == CMD_PUSH;
	assign pop_fire   = fire_s1 && item_s1.command == CMD_POP;
	assign ring_empty = wr_q == rd_q;
	assign rd_en      = pop_fire && !ring_empty;
	assign in_stall   = v_s1 && !fire_s1;
	assign accept     = in_valid && !in_stall;

	assign wr_next = (wr_q == RING_AW'(RING_FRAMES - 1)) ? '0 : wr_q + 1'b1;
	assign rd_next = (rd_q == RING_AW'(RING_FRAMES - 1)) ? '0 : rd_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (fire_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_word;
		end
	end

	dbm_mix u_mix (
		.word     (item_s1),
		.dc_est   (dc_q),
		.gain     (gain_q),
		.dc_shift (dc_shift_q),
		.sample   (mix_sample),
		.dc_next  (dc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= '0;
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push_fire) begin
				dc_q <= dc_next;
				wr_q <= wr_next;
			end
			if (rd_en) begin
				rd_q <= rd_next;
			end
		end
	end

	dbm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_FRAMES)
	) u_ring (
		.clk   (clk),
		.we    (push_fire),
		.waddr (wr_q),
		.wdata (mix_sample),
		.re    (rd_en),
		.raddr (rd_q),
		.rdata (ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			fv_s2 <= 1'b0;
		end else if (s2_open) begin
			v_s2 <= pop_fire;
			if (pop_fire) begin
				fv_s2 <= !ring_empty;
			end
		end
	end

	assign out_valid             = v_s2;
	assign out_word.left_sample  = fv_s2 ? $signed(ring_rdata) : '0;
	assign out_word.right_sample = fv_s2 ? $signed(ring_rdata) : '0;
	assign out_word.frame_valid  = fv_s2;

	`DBM_ASSERT(a_dc_range, dc_q <= DC_MAX, "DC estimate left the mix range")
	`DBM_ASSERT_NEXT(a_empty_pop_holds, pop_fire && ring_empty, $stable(rd_q),
		"read index moved on an empty pop")
	`DBM_ASSERT_NEXT(a_push_advances, push_fire, wr_q != $past(wr_q),
		"write index did not advance on push")
	`DBM_ASSERT(a_stall_only_for_pop,
		in_stall |-> (item_s1.command == CMD_POP && v_s2 && out_stall),
		"input stalled without a blocked pop")

endmodule

### verif/dc_blocked_mixer_ring_top_tb.sv
module dc_blocked_mixer_ring_top_tb;
	import dbm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	in_word_t          in_word   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_word_t         out_word;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	cfg_reg_t          cfg_index = REG_GAIN;
	logic [GAIN_W-1:0] cfg_data  = '0;

	dc_blocked_mixer_ring_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mixer state as the block should hold it
	logic [GAIN_W-1:0]          mix_gain = GAIN_RESET;
	logic [SHIFT_W-1:0]         dc_pole  = SHIFT_RESET;
	int                         dc_level = 0;
	logic signed [SAMPLE_W-1:0] ring_samples [RING_FRAMES];
	logic [RING_AW-1:0]         ring_wr  = '0;
	logic [RING_AW-1:0]         ring_rd  = '0;

	in_word_t    pending_words [$];
	out_word_t   expected_frames [$];
	out_word_t   head_frame;
	int unsigned fail_count = 0;
	int unsigned in_gap     = 0;
	int unsigned out_hold   = 0;
	bit          quiet_in   = 1'b0;
	bit          quiet_out  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("dc_blocked_mixer_ring_top regression: fail");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic in_word_t mix_word(logic [7:0] p1, logic [7:0] p2, logic [7:0] tri_s,
			logic [7:0] noise, logic [7:0] dpcm);
		in_word_t w;
		w.command        = CMD_PUSH;
		w.wave_pulse_one = p1;
		w.wave_pulse_two = p2;
		w.wave_triangle  = tri_s;
		w.wave_noise     = noise;
		w.wave_dpcm      = dpcm;
		return w;
	endfunction

	function automatic in_word_t make_push();
		int unsigned flavor;
		logic [7:0]  lvl;
		flavor = $urandom_range(9);
		lvl    = 8'($urandom);
		if (flavor < 5)
			return mix_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom));
		if (flavor < 8)   // steady level lets the DC tracker settle
			return mix_word(lvl, lvl, lvl, lvl, lvl);
		return mix_word({8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
			{8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
			{8{$urandom_range(1) == 1}});
	endfunction

	function automatic in_word_t make_pop();
		in_word_t w;
		w         = make_push();
		w.command = CMD_POP;
		return w;
	endfunction

	task automatic predict_mix(input in_word_t w);
		int        mix_sum;
		int        ac;
		int        prod;
		out_word_t frame;
		if (w.command == CMD_PUSH) begin
			mix_sum = int'(w.wave_pulse_one) + int'(w.wave_pulse_two) + int'(w.wave_triangle)
				+ int'(w.wave_noise) + int'(w.wave_dpcm);
			ac = mix_sum - dc_level;
			dc_level += ac >>> dc_pole;   // floors on negative differences
			prod = ac * int'(mix_gain);
			if (prod > SAT_MAX)
				prod = SAT_MAX;
			else if (prod < SAT_MIN)
				prod = SAT_MIN;
			ring_samples[ring_wr] = prod[SAMPLE_W-1:0];
			ring_wr++;
		end else begin
			frame = '0;
			if (ring_wr != ring_rd) begin
				frame.left_sample  = ring_samples[ring_rd];
				frame.right_sample = ring_samples[ring_rd];
				frame.frame_valid  = 1'b1;
				ring_rd++;
			end
			expected_frames.push_back(frame);
		end
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				predict_mix(in_word);
			if (in_gap != 0) begin
				in_gap   <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				in_word  <= pending_words.pop_front();
				in_valid <= 1'b1;
				in_gap   <= quiet_in ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold  <= 0;
		end else if (out_hold != 0) begin
			out_stall <= 1'b1;
			out_hold  <= out_hold - 1;
		end else begin
			out_stall <= 1'b0;
			out_hold  <= quiet_out ? 0 : pick_gap();
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				$error("output word with no pop pending: left %0d right %0d valid %0b",
					out_word.left_sample, out_word.right_sample, out_word.frame_valid);
				fail_count++;
			end else begin
				head_frame = expected_frames.pop_front();
				if (out_word.left_sample !== head_frame.left_sample) begin
					$error("left_sample: expected %0d, got %0d",
						head_frame.left_sample, out_word.left_sample);
					fail_count++;
				end
				if (out_word.right_sample !== head_frame.right_sample) begin
					$error("right_sample: expected %0d, got %0d",
						head_frame.right_sample, out_word.right_sample);
					fail_count++;
				end
				if (out_word.frame_valid !== head_frame.frame_valid) begin
					$error("frame_valid: expected %0b, got %0b",
						head_frame.frame_valid, out_word.frame_valid);
					fail_count++;
				end
			end
		end
	end

	// wait for all words taken and all frames back, then let a trailing push settle
	task automatic drain();
		while (pending_words.size() != 0 || in_valid || expected_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [GAIN_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_GAIN)
			mix_gain = value;
		else
			dc_pole = value[SHIFT_W-1:0];
	endtask

	task automatic retune();
		logic [GAIN_W-1:0]  g;
		logic [SHIFT_W-1:0] s;
		case ($urandom_range(3))
			0:       g = '0;
			1:       g = '1;
			default: g = GAIN_W'($urandom);
		endcase
		case ($urandom_range(3))
			0:       s = '0;
			1:       s = '1;
			default: s = SHIFT_W'($urandom);
		endcase
		write_reg(REG_GAIN, g);
		write_reg(REG_DC_SHIFT, {6'($urandom), s});
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty pop, silence, full scale
		pending_words.push_back(make_pop());
		pending_words.push_back(mix_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		pending_words.push_back(mix_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		repeat (3) pending_words.push_back(make_pop());
		drain();

		// max gain, instant tracker: clamp both ways
		write_reg(REG_GAIN, '1);
		write_reg(REG_DC_SHIFT, {6'b000000, 4'd0});
		pending_words.push_back(mix_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		pending_words.push_back(mix_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		pending_words.push_back(mix_word(8'h00, 8'h00, 8'h01, 8'h00, 8'h00));
		repeat (4) pending_words.push_back(make_pop());
		drain();

		// zero gain, slowest tracker
		write_reg(REG_GAIN, '0);
		write_reg(REG_DC_SHIFT, {6'b111111, 4'd15});
		pending_words.push_back(mix_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		pending_words.push_back(mix_word(8'h80, 8'h80, 8'h80, 8'h80, 8'h80));
		repeat (2) pending_words.push_back(make_pop());
		drain();

		// mid gain, mid tracker: short burst, then pops past empty
		write_reg(REG_GAIN, 10'd777);
		write_reg(REG_DC_SHIFT, {6'b010101, 4'd4});
		repeat (int'(RING_AW'(ring_wr - ring_rd))) pending_words.push_back(make_pop());
		repeat (3) pending_words.push_back(make_push());
		repeat (4) pending_words.push_back(make_pop());
		drain();

		for (int seg = 0; seg < 6; seg++) begin
			int unsigned push_pct;
			retune();
			push_pct = $urandom_range(70, 30);
			for (int k = 0; k < 240; k++) begin
				if (k % 60 == 0) begin
					quiet_in  = ($urandom_range(3) == 0);
					quiet_out = ($urandom_range(3) == 0);
				end
				if ($urandom_range(99) < push_pct)
					pending_words.push_back(make_push());
				else
					pending_words.push_back(make_pop());
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_frames.size() == 0)
			$display("dc_blocked_mixer_ring_top regression: pass");
		else
			$display("dc_blocked_mixer_ring_top regression: fail");
		$finish;
	end

endmodule
